FILE: sv/pwbc_pkg.sv
// ----------------------------------------------------------------------------
// pwbc_pkg
// Types, sizes and codes shared by the page write-back cache modules.
// ----------------------------------------------------------------------------
package pwbc_pkg;

  localparam int CACHE_LINES = 8;
  // PAGE_BYTES and STORE_PAGES are powers of two: page and offset are bit fields.
  localparam int PAGE_BYTES  = 4096;
  localparam int STORE_PAGES = 64;

  localparam int ADDR_W   = 24;
  localparam int DATA_W   = 8;
  localparam int STAMP_W  = 32;
  localparam int REL_W    = 4;
  localparam int OFF_W    = $clog2(PAGE_BYTES);
  localparam int PAGE_W   = ADDR_W - OFF_W;
  localparam int LINE_W   = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
  localparam int SPAGE_W  = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
  localparam int LBYTES_DEPTH = CACHE_LINES * PAGE_BYTES;
  localparam int STORE_DEPTH  = STORE_PAGES * PAGE_BYTES;
  localparam int LBYTES_AW    = $clog2(LBYTES_DEPTH);
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 16;
  localparam int PADDR_W      = 3;

  localparam logic [STAMP_W-1:0] MAX_AGE_RESET = 32'd5000;
  localparam logic [STAMP_W-1:0] STAMP_MAX     = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0]  ERASED_BYTE   = 8'hFF;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_NO_VICTIM = 2'd2;

  localparam logic REG_MAX_AGE = 1'b0;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_SYNC  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_DATA,
    ST_WR_ISSUE,
    ST_WR_UPD,
    ST_FILL,
    ST_FLUSH,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              inval;
    logic [LINE_W-1:0] inval_idx;
    logic              alloc;
    logic [LINE_W-1:0] alloc_idx;
    logic [SPAGE_W-1:0] alloc_page;
    logic              touch;
    logic [LINE_W-1:0] touch_idx;
  } tag_cmd_t;

  typedef struct packed {
    logic               hit;
    logic [LINE_W-1:0]  hit_idx;
    logic               free_found;
    logic [LINE_W-1:0]  free_idx;
    logic               victim_found;
    logic [LINE_W-1:0]  victim_idx;
    logic               victim_dirty;
    logic [SPAGE_W-1:0] victim_page;
    logic               sel_valid;
    logic               sel_dirty;
    logic [SPAGE_W-1:0] sel_page;
    logic               sel_aged;
  } tag_info_t;

endpackage

FILE: sv/pwbc_ram.sv
// ----------------------------------------------------------------------------
// pwbc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pwbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/pwbc_tags.sv
// ----------------------------------------------------------------------------
// pwbc_tags
// Line tags: valid, page, dirty and stamp per line, with lookup, free-line
// search, oldest-line victim choice and the age check of one selected line.
// ----------------------------------------------------------------------------
module pwbc_tags (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pwbc_pkg::SPAGE_W-1:0]  lookup_page_i,
  input  logic [pwbc_pkg::LINE_W-1:0]   sel_idx_i,
  input  logic [pwbc_pkg::STAMP_W-1:0]  now_i,
  input  logic [pwbc_pkg::STAMP_W-1:0]  max_age_i,
  input  pwbc_pkg::tag_cmd_t            cmd_i,
  output pwbc_pkg::tag_info_t           info_o
);
  import pwbc_pkg::*;

  logic [CACHE_LINES-1:0] valid_q, valid_d;
  logic [CACHE_LINES-1:0] dirty_q, dirty_d;
  logic [SPAGE_W-1:0]     page_q  [CACHE_LINES];
  logic [SPAGE_W-1:0]     page_d  [CACHE_LINES];
  logic [STAMP_W-1:0]     stamp_q [CACHE_LINES];
  logic [STAMP_W-1:0]     stamp_d [CACHE_LINES];

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    page_d  = page_q;
    stamp_d = stamp_q;
    if (cmd_i.inval) begin
      valid_d[cmd_i.inval_idx] = 1'b0;
      dirty_d[cmd_i.inval_idx] = 1'b0;
    end
    if (cmd_i.alloc) begin
      valid_d[cmd_i.alloc_idx] = 1'b1;
      dirty_d[cmd_i.alloc_idx] = 1'b0;
      page_d[cmd_i.alloc_idx]  = cmd_i.alloc_page;
      stamp_d[cmd_i.alloc_idx] = now_i;
    end
    if (cmd_i.touch) begin
      dirty_d[cmd_i.touch_idx] = 1'b1;
      stamp_d[cmd_i.touch_idx] = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int n = 0; n < CACHE_LINES; n++) begin
        page_q[n]  <= '0;
        stamp_q[n] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      page_q  <= page_d;
      stamp_q <= stamp_d;
    end
  end

  logic [STAMP_W-1:0] min_stamp;
  logic [STAMP_W-1:0] sel_age;

  always_comb begin
    info_o = '0;
    min_stamp = STAMP_MAX;
    // Downward scans so that the lowest matching line wins.
    for (int n = CACHE_LINES - 1; n >= 0; n--) begin
      if (valid_q[n] && page_q[n] == lookup_page_i) begin
        info_o.hit     = 1'b1;
        info_o.hit_idx = LINE_W'(n);
      end
      if (!valid_q[n]) begin
        info_o.free_found = 1'b1;
        info_o.free_idx   = LINE_W'(n);
      end
    end
    // Strict compare keeps the first line among equal stamps.
    for (int n = 0; n < CACHE_LINES; n++) begin
      if (stamp_q[n] < min_stamp) begin
        min_stamp           = stamp_q[n];
        info_o.victim_found = 1'b1;
        info_o.victim_idx   = LINE_W'(n);
      end
    end
    info_o.victim_dirty = dirty_q[info_o.victim_idx];
    info_o.victim_page  = page_q[info_o.victim_idx];
    sel_age          = now_i - stamp_q[sel_idx_i];
    info_o.sel_valid = valid_q[sel_idx_i];
    info_o.sel_dirty = dirty_q[sel_idx_i];
    info_o.sel_page  = page_q[sel_idx_i];
    info_o.sel_aged  = (sel_age >= max_age_i);
  end

endmodule

FILE: sv/page_write_back_cache_core.sv
// ----------------------------------------------------------------------------
// page_write_back_cache_core
// Fully associative write-back page cache over an erased byte store.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser carries the operation (read byte,
// write byte, age tick, sync all), tdata the address, write byte and time,
// tlast marks the end of a multi-byte access and has no effect. Every item
// gives exactly one result item on m_axis. The max_age_ms register sits at
// APB address 0.
// A read passes through the decode and read-data states to the result; a
// write hit through decode, issue and update. A write miss with no free line
// first flushes the victim if it is dirty, then fills the line, each a page
// copy through the line RAM and store RAM. Tick and sync visit every line in
// turn and flush each dirty line they release. One item is worked on at a time.
// The result sits in an output register; the next item is taken while it
// waits, but the following result is held until the receiver takes it.
// Reset clears all line tags and marks every store page as erased, so the
// store reads 0xFF until a page is written back; no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_write_back_cache_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // address [23:0], write_data [31:24], now_ms [63:32]
  input  logic [pwbc_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // operation [1:0]
  input  logic [1:0]                        s_axis_tuser_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // read_data [7:0], status [9:8], hit [10], lines_released [14:11], zero [15]
  output logic [pwbc_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [pwbc_pkg::PADDR_W-1:0]      paddr_i,
  input  logic [31:0]                       pwdata_i,
  output logic [31:0]                       prdata_o,
  output logic                              pready_o
);
  import pwbc_pkg::*;

  state_e             state_q, state_d;
  op_e                op_q;
  logic [PAGE_W-1:0]  page_q;
  logic [OFF_W-1:0]   off_q;
  logic [DATA_W-1:0]  wdata_q;
  logic [STAMP_W-1:0] now_q;
  logic [LINE_W-1:0]  line_q, line_d;
  logic [LINE_W-1:0]  scan_q, scan_d;
  logic [OFF_W:0]     cnt_q, cnt_d;
  logic [SPAGE_W-1:0] flush_page_q, flush_page_d;
  logic [REL_W-1:0]   rel_q, rel_d;
  logic               hit_q, hit_d;
  logic               from_line_q, from_line_d;
  logic [1:0]         status_q, status_d;
  logic [DATA_W-1:0]  rdata_q, rdata_d;
  logic [STAMP_W-1:0] max_age_q;
  logic [STORE_PAGES-1:0] written_q;
  logic               m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic               accept;
  logic               out_load;
  logic               mark_page;
  logic               in_range;
  logic [SPAGE_W-1:0] spage;
  logic [OFF_W-1:0]   cnt_prev;
  logic               copy_end;

  logic                 lb_we, st_we;
  logic [LBYTES_AW-1:0] lb_waddr, lb_raddr;
  logic [STORE_AW-1:0]  st_waddr, st_raddr;
  logic [DATA_W-1:0]    lb_wdata, st_wdata, lb_rdata, st_rdata;
  logic [DATA_W-1:0]    store_byte;

  tag_cmd_t  cmd;
  tag_info_t info;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign spage    = page_q[SPAGE_W-1:0];
  assign in_range = (page_q < PAGE_W'(STORE_PAGES));
  assign cnt_prev = OFF_W'(cnt_q - 1'b1);
  assign copy_end = (cnt_q == (OFF_W+1)'(PAGE_BYTES));
  // A page never written back still reads as erased flash.
  assign store_byte = written_q[spage] ? st_rdata : ERASED_BYTE;

  pwbc_tags u_tags (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lookup_page_i (spage),
    .sel_idx_i     (scan_q),
    .now_i         (now_q),
    .max_age_i     (max_age_q),
    .cmd_i         (cmd),
    .info_o        (info)
  );

  pwbc_ram #(.WIDTH(DATA_W), .DEPTH(LBYTES_DEPTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (lb_waddr),
    .wdata_i (lb_wdata),
    .raddr_i (lb_raddr),
    .rdata_o (lb_rdata)
  );

  pwbc_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  always_comb begin
    state_d      = state_q;
    line_d       = line_q;
    scan_d       = scan_q;
    cnt_d        = cnt_q;
    flush_page_d = flush_page_q;
    rel_d        = rel_q;
    hit_d        = hit_q;
    from_line_d  = from_line_q;
    status_d     = status_q;
    rdata_d      = rdata_q;
    cmd          = '0;
    lb_we        = 1'b0;
    lb_waddr     = {line_q, cnt_prev};
    lb_wdata     = store_byte;
    lb_raddr     = {line_q, off_q};
    st_we        = 1'b0;
    st_waddr     = {flush_page_q, cnt_prev};
    st_wdata     = lb_rdata;
    st_raddr     = {spage, off_q};
    mark_page    = 1'b0;
    out_load     = 1'b0;
    s_axis_tready_o = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rel_d       = '0;
          hit_d       = 1'b0;
          from_line_d = 1'b0;
          status_d    = STATUS_OK;
          rdata_d     = '0;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (op_q == OP_TICK || op_q == OP_SYNC) begin
          scan_d  = '0;
          state_d = ST_SCAN;
        end else if (!in_range) begin
          status_d = STATUS_RANGE;
          state_d  = ST_DONE;
        end else if (op_q == OP_READ) begin
          lb_raddr    = {info.hit_idx, off_q};
          hit_d       = info.hit;
          from_line_d = info.hit;
          state_d     = ST_RD_DATA;
        end else if (info.hit) begin
          hit_d   = 1'b1;
          line_d  = info.hit_idx;
          state_d = ST_WR_ISSUE;
        end else if (info.free_found) begin
          line_d  = info.free_idx;
          cnt_d   = '0;
          state_d = ST_FILL;
        end else if (info.victim_found) begin
          line_d = info.victim_idx;
          rel_d  = REL_W'(1);
          cnt_d  = '0;
          if (info.victim_dirty) begin
            flush_page_d = info.victim_page;
            state_d      = ST_FLUSH;
          end else begin
            cmd.inval     = 1'b1;
            cmd.inval_idx = info.victim_idx;
            state_d       = ST_FILL;
          end
        end else begin
          status_d = STATUS_NO_VICTIM;
          state_d  = ST_DONE;
        end
      end
      ST_RD_DATA: begin
        rdata_d = from_line_q ? lb_rdata : store_byte;
        state_d = ST_DONE;
      end
      ST_WR_ISSUE: begin
        state_d = ST_WR_UPD;
      end
      ST_WR_UPD: begin
        lb_we    = 1'b1;
        lb_waddr = {line_q, off_q};
        lb_wdata = wdata_q;
        if (lb_rdata != wdata_q) begin
          cmd.touch     = 1'b1;
          cmd.touch_idx = line_q;
        end
        state_d = ST_DONE;
      end
      ST_FILL: begin
        st_raddr = {spage, cnt_q[OFF_W-1:0]};
        lb_we    = (cnt_q != '0);
        cnt_d    = cnt_q + 1'b1;
        if (copy_end) begin
          cmd.alloc      = 1'b1;
          cmd.alloc_idx  = line_q;
          cmd.alloc_page = spage;
          state_d        = ST_WR_ISSUE;
        end
      end
      ST_FLUSH: begin
        lb_raddr = {line_q, cnt_q[OFF_W-1:0]};
        st_we    = (cnt_q != '0);
        cnt_d    = cnt_q + 1'b1;
        if (copy_end) begin
          cmd.inval     = 1'b1;
          cmd.inval_idx = line_q;
          mark_page     = 1'b1;
          if (op_q == OP_WRITE) begin
            cnt_d   = '0;
            state_d = ST_FILL;
          end else if (scan_q == LINE_W'(CACHE_LINES - 1)) begin
            state_d = ST_DONE;
          end else begin
            scan_d  = scan_q + 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (info.sel_valid && (op_q == OP_SYNC || info.sel_aged)) begin
          rel_d = rel_q + 1'b1;
        end
        if (info.sel_valid && (op_q == OP_SYNC || info.sel_aged) && info.sel_dirty) begin
          line_d       = scan_q;
          flush_page_d = info.sel_page;
          cnt_d        = '0;
          state_d      = ST_FLUSH;
        end else begin
          if (info.sel_valid && (op_q == OP_SYNC || info.sel_aged)) begin
            cmd.inval     = 1'b1;
            cmd.inval_idx = scan_q;
          end
          if (scan_q == LINE_W'(CACHE_LINES - 1)) begin
            state_d = ST_DONE;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      max_age_q <= MAX_AGE_RESET;
      written_q <= '0;
      scan_q    <= '0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (psel_i && penable_i && pwrite_i && pready_o && paddr_i[2] == REG_MAX_AGE) begin
        max_age_q <= pwdata_i;
      end
      if (mark_page) begin
        written_q[flush_page_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(s_axis_tuser_i);
      page_q  <= s_axis_tdata_i[ADDR_W-1:OFF_W];
      off_q   <= s_axis_tdata_i[OFF_W-1:0];
      wdata_q <= s_axis_tdata_i[ADDR_W+DATA_W-1:ADDR_W];
      now_q   <= s_axis_tdata_i[ADDR_W+DATA_W+STAMP_W-1:ADDR_W+DATA_W];
    end
    line_q       <= line_d;
    flush_page_q <= flush_page_d;
    rel_q        <= rel_d;
    hit_q        <= hit_d;
    from_line_q  <= from_line_d;
    status_q     <= status_d;
    rdata_q      <= rdata_d;
    if (out_load) begin
      m_data_q <= {1'b0, rel_q, hit_q, status_q, rdata_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign pready_o        = 1'b1;
  assign prdata_o        = (paddr_i[2] == REG_MAX_AGE) ? max_age_q : 32'd0;

  // tlast only marks access boundaries; the cache does not depend on it.
  logic unused_last;
  assign unused_last = s_axis_tlast_i;

endmodule

FILE: sv/pwbc_checker.sv
// ----------------------------------------------------------------------------
// pwbc_checker
// Port-level checks for the page write-back cache, bound to the top level.
// ----------------------------------------------------------------------------
module pwbc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [pwbc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                            pready_o
);
  import pwbc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result item changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[9:8] != 2'd3)
    else $error("undefined status code");

  // A failed read or write leaves every other result field at zero.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[9:8] != STATUS_OK |->
      m_axis_tdata_o[7:0] == 8'd0 && !m_axis_tdata_o[10] && m_axis_tdata_o[14:11] == 4'd0)
    else $error("failed item reports data");

  a_hit_no_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[10] |-> m_axis_tdata_o[14:11] == 4'd0)
    else $error("hit released a line");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("configuration port stalled");

endmodule

bind page_write_back_cache_core pwbc_checker u_pwbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .pready_o        (pready_o)
);
